// ===== hw/rtl/lss_pkg.sv =====
// Package for the line segment step sampler: beat structs, state encoding,
// widths and reset constants. Depends on nothing; used by every RTL file.
`timescale 1ns / 1ps

package lss_pkg;

  // Field widths fixed by the segment and point formats.
  localparam int unsigned PosW  = 32;  // signed Q16.16 positions
  localparam int unsigned DirW  = 16;  // signed Q1.15 direction components
  localparam int unsigned LenW  = 32;  // unsigned Q16.16 lengths
  // Low bits of dir * offset that matter: bits [46:15] form the wrapped coordinate.
  localparam int unsigned ProdW = PosW + 15;
  localparam int unsigned FracShift = 15;

  localparam int unsigned      MAX_STEPS_DEF  = 63;
  localparam logic [LenW-1:0]  STEP_SIZE_RST  = 32'h0002_0000;  // 2.0

  // One input beat: a segment.
  typedef struct packed {
    logic signed [PosW-1:0] start_x;
    logic signed [PosW-1:0] start_y;
    logic signed [PosW-1:0] start_z;
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
    logic signed [DirW-1:0] dir_z;
    logic [LenW-1:0]        seg_length;
  } in_item_t;

  // One result beat: a weighted sample point.
  typedef struct packed {
    logic signed [PosW-1:0] point_x;
    logic signed [PosW-1:0] point_y;
    logic signed [PosW-1:0] point_z;
    logic [LenW-1:0]        weight;
    logic                   last;
    logic                   truncated;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_STEP,
    ST_MUL_HALF,
    ST_STEPS,
    ST_MUL_FIN,
    ST_EMIT_FIN
  } state_t;

endpackage

// ===== hw/rtl/lss_mul.sv =====
// Shared multiplier of the step sampler: signed Q1.15 direction times an
// unsigned Q16.16 offset, low product bits only. Depends on lss_pkg.
`timescale 1ns / 1ps

module lss_mul (
  input  logic signed [lss_pkg::DirW-1:0]  dir,
  input  logic [lss_pkg::LenW-1:0]         offs,
  output logic [lss_pkg::ProdW-1:0]        prod
);

  localparam int unsigned FullW = lss_pkg::DirW + lss_pkg::LenW + 1;

  logic signed [FullW-1:0] full;

  // Zero-extend the offset so the product is signed times unsigned.
  always_comb begin
    full = FullW'($signed(dir) * $signed({1'b0, offs}));
    prod = full[lss_pkg::ProdW-1:0];
  end

endmodule

// ===== hw/rtl/line_segment_step_sampler.sv =====
// Top level of the line segment step sampler: command port, step register,
// sequencer and point datapath. Depends on lss_pkg and lss_mul.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   in_     | in        | start / busy           | in_data (segment)
//   out_    | out       | out_valid strobe       | out_data (weighted point)
//   cfg_    | in        | cfg_valid / cfg_ready  | cfg_data (step size)
//
// A segment shorter than the step gives one point at its midpoint; otherwise n
// whole steps (at most MAX_STEPS) and a remainder point. One multiplier is shared:
// it scales the step per axis, then the half step, then the final offset;
// the step points then come one a cycle from running sums. busy is high from
// the accept and falls in the cycle that strobes the final point. rst_n is
// synchronous and sets the step to 2.0. The receiver cannot stall; a point is
// shown one cycle.
`timescale 1ns / 1ps

module line_segment_step_sampler #(
  parameter int unsigned MAX_STEPS = lss_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lss_pkg::in_item_t           in_data,
  output logic                        out_valid,
  output lss_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lss_pkg::LenW-1:0]    cfg_data
);

  localparam int unsigned CntW = $clog2(MAX_STEPS + 1);
  localparam int unsigned CovW = lss_pkg::LenW + CntW;
  localparam int unsigned PW   = lss_pkg::ProdW;
  localparam int unsigned LW   = lss_pkg::LenW;

  typedef struct packed {
    logic [LW-1:0] mul_d;      // offset fed to the multiplier
    logic          more;       // another whole step to emit
    logic          step_emit;  // step point emitted this cycle
    logic          axis_done;  // multiplier on the last axis
  } ctrl_t;

  lss_pkg::state_t state_r, state_nxt;
  ctrl_t           ctrl;

  logic [LW-1:0]                  step_r;
  logic signed [lss_pkg::PosW-1:0] start_r [3];
  logic signed [lss_pkg::DirW-1:0] dir_r   [3];
  logic [PW-1:0]                  inc_r   [3];
  logic [PW-1:0]                  acc_r   [3];
  logic [LW-1:0]                  len_r;
  logic [LW-1:0]                  fin_d_r;
  logic [LW-1:0]                  wt_r;
  logic                           trunc_r;
  logic [CovW-1:0]                cov_r;
  logic [CntW-1:0]                cnt_r;
  logic [1:0]                     axis_r;
  logic                           out_valid_r;
  lss_pkg::out_item_t             out_data_r;

  logic [CovW-1:0]                cap;
  logic [CovW-1:0]                cov_next;
  logic [LW-1:0]                  rem;
  logic [PW-1:0]                  prod;
  logic [lss_pkg::PosW-1:0]       fin_pt;
  logic                           accept;

  assign accept    = start && (state_r == lss_pkg::ST_IDLE);
  assign busy      = (state_r != lss_pkg::ST_IDLE);
  // The step is not changed in the cycle that takes a segment.
  assign cfg_ready = (state_r == lss_pkg::ST_IDLE) && !start;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Whole-step threshold for truncation and running covered length.
  assign cap      = CovW'(in_data.seg_length) < CovW'(step_r) * CovW'(MAX_STEPS + 1)
                    ? '0 : '1;
  assign cov_next = cov_r + CovW'(step_r);
  assign rem      = len_r - cov_r[LW-1:0];

  // Shared multiplier.
  lss_mul u_mul (
    .dir  (dir_r[axis_r]),
    .offs (ctrl.mul_d),
    .prod (prod)
  );

  assign fin_pt = start_r[axis_r] + prod[PW-1:lss_pkg::FracShift];

  // Sequencer controls.
  always_comb begin
    ctrl = '0;
    ctrl.axis_done = (axis_r == 2'd2);
    ctrl.more = trunc_r ? (cnt_r != CntW'(MAX_STEPS))
                        : (CovW'(len_r) >= cov_next);
    unique case (state_r)
      lss_pkg::ST_MUL_STEP: ctrl.mul_d = step_r;
      lss_pkg::ST_MUL_HALF: ctrl.mul_d = step_r >> 1;
      lss_pkg::ST_MUL_FIN:  ctrl.mul_d = fin_d_r;
      lss_pkg::ST_STEPS:    ctrl.step_emit = ctrl.more;
      default:              ctrl.mul_d = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lss_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_data.seg_length < step_r) ? lss_pkg::ST_MUL_FIN
                                                    : lss_pkg::ST_MUL_STEP;
        end
      end
      lss_pkg::ST_MUL_STEP: begin
        if (ctrl.axis_done) state_nxt = lss_pkg::ST_MUL_HALF;
      end
      lss_pkg::ST_MUL_HALF: begin
        if (ctrl.axis_done) state_nxt = lss_pkg::ST_STEPS;
      end
      lss_pkg::ST_STEPS: begin
        if (!ctrl.more) state_nxt = lss_pkg::ST_MUL_FIN;
      end
      lss_pkg::ST_MUL_FIN: begin
        if (ctrl.axis_done) state_nxt = lss_pkg::ST_EMIT_FIN;
      end
      lss_pkg::ST_EMIT_FIN: state_nxt = lss_pkg::ST_IDLE;
      default:              state_nxt = lss_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lss_pkg::ST_IDLE;
      step_r      <= lss_pkg::STEP_SIZE_RST;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctrl.step_emit || (state_r == lss_pkg::ST_EMIT_FIN);
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_data;
      end
      // Axis counter runs through x, y, z in each multiply state.
      if (state_r == lss_pkg::ST_MUL_STEP || state_r == lss_pkg::ST_MUL_HALF ||
          state_r == lss_pkg::ST_MUL_FIN) begin
        axis_r <= ctrl.axis_done ? 2'd0 : axis_r + 2'd1;
      end else begin
        axis_r <= 2'd0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      lss_pkg::ST_IDLE: begin
        if (accept) begin
          start_r[0] <= in_data.start_x;
          start_r[1] <= in_data.start_y;
          start_r[2] <= in_data.start_z;
          dir_r[0]   <= in_data.dir_x;
          dir_r[1]   <= in_data.dir_y;
          dir_r[2]   <= in_data.dir_z;
          len_r      <= in_data.seg_length;
          cov_r      <= '0;
          cnt_r      <= '0;
          if (in_data.seg_length < step_r) begin
            // Short segment: one point at the midpoint.
            fin_d_r <= in_data.seg_length >> 1;
            wt_r    <= in_data.seg_length;
            trunc_r <= 1'b0;
          end else begin
            trunc_r <= cap[0];
          end
        end
      end
      lss_pkg::ST_MUL_STEP: inc_r[axis_r] <= prod;
      lss_pkg::ST_MUL_HALF: acc_r[axis_r] <= prod;
      lss_pkg::ST_STEPS: begin
        if (ctrl.more) begin
          // Step point, then advance the running products by one step.
          out_data_r.point_x   <= start_r[0] + acc_r[0][PW-1:lss_pkg::FracShift];
          out_data_r.point_y   <= start_r[1] + acc_r[1][PW-1:lss_pkg::FracShift];
          out_data_r.point_z   <= start_r[2] + acc_r[2][PW-1:lss_pkg::FracShift];
          out_data_r.weight    <= step_r;
          out_data_r.last      <= 1'b0;
          out_data_r.truncated <= trunc_r;
          acc_r[0] <= acc_r[0] + inc_r[0];
          acc_r[1] <= acc_r[1] + inc_r[1];
          acc_r[2] <= acc_r[2] + inc_r[2];
          cov_r    <= cov_next;
          cnt_r    <= cnt_r + CntW'(1);
        end else begin
          // Remainder point sits in the middle of what is left.
          fin_d_r <= len_r - (rem >> 1);
          wt_r    <= rem;
        end
      end
      lss_pkg::ST_MUL_FIN: begin
        case (axis_r)
          2'd0:    out_data_r.point_x <= fin_pt;
          2'd1:    out_data_r.point_y <= fin_pt;
          default: out_data_r.point_z <= fin_pt;
        endcase
      end
      lss_pkg::ST_EMIT_FIN: begin
        out_data_r.weight    <= wt_r;
        out_data_r.last      <= 1'b1;
        out_data_r.truncated <= trunc_r;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

// ===== tb/tb_line_segment_step_sampler.sv =====
// Self-checking testbench for the line segment step sampler: directed and random
// segments under several step sizes, checked point by point. Needs lss_pkg, the DUT.
`timescale 1ns / 1ps

module tb_line_segment_step_sampler;

  localparam int unsigned MaxSteps    = lss_pkg::MAX_STEPS_DEF;
  localparam int unsigned SettleTicks = 8;     // quiet cycles before a step change
  localparam int unsigned QuietLimit  = 1000;  // cycles with no beat at all
  localparam int unsigned PhaseItems  = 77;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  lss_pkg::in_item_t            in_data;
  logic                         out_valid;
  lss_pkg::out_item_t           out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [lss_pkg::LenW-1:0]     cfg_data;

  // Predicted points waiting for the DUT, oldest first.
  lss_pkg::out_item_t           expected_points[$];
  logic [lss_pkg::LenW-1:0]     step_model;
  int unsigned                  error_count;
  int unsigned                  quiet_cycles;
  bit                           back_to_back;

  line_segment_step_sampler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // One coordinate: origin plus floor(dir * offset / 2^15), wrapped to 32 bits.
  function automatic logic [lss_pkg::PosW-1:0] axis_point(
      input logic [lss_pkg::PosW-1:0] org,
      input logic signed [lss_pkg::DirW-1:0] dir,
      input logic [63:0] off);
    longint prod;
    longint shifted;
    prod    = longint'(dir) * longint'(off);
    shifted = prod >>> 15;
    return org + shifted[lss_pkg::PosW-1:0];
  endfunction

  function automatic void push_point(input lss_pkg::in_item_t seg, input logic [63:0] off,
                                     input logic [63:0] wt, input bit fin,
                                     input bit capped);
    lss_pkg::out_item_t pt;
    pt.point_x   = axis_point(seg.start_x, seg.dir_x, off);
    pt.point_y   = axis_point(seg.start_y, seg.dir_y, off);
    pt.point_z   = axis_point(seg.start_z, seg.dir_z, off);
    pt.weight    = wt[lss_pkg::LenW-1:0];
    pt.last      = fin;
    pt.truncated = capped;
    expected_points.push_back(pt);
  endfunction

  // Works out every sample point of one segment under the current step.
  function automatic void predict_points(input lss_pkg::in_item_t seg);
    logic [63:0] len;
    logic [63:0] stp;
    logic [63:0] n;
    logic [63:0] rem;
    logic [63:0] i;
    bit          capped;
    len    = seg.seg_length;
    stp    = step_model;
    capped = 1'b0;
    // A segment shorter than the step is one point at its midpoint.
    if (len < stp) begin
      push_point(seg, len >> 1, len, 1'b1, 1'b0);
      return;
    end
    // A zero step counts as an unbounded number of steps.
    if (stp == 0) begin
      n      = MaxSteps;
      capped = 1'b1;
    end else begin
      n = len / stp;
      if (n > MaxSteps) begin
        n      = MaxSteps;
        capped = 1'b1;
      end
    end
    for (i = 0; i < n; i++) begin
      push_point(seg, stp * i + (stp >> 1), stp, 1'b0, capped);
    end
    // The remainder point is always emitted, even with nothing left over.
    rem = len - stp * n;
    push_point(seg, len - (rem >> 1), rem, 1'b1, capped);
  endfunction

  function automatic lss_pkg::in_item_t make_segment(
      input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
      input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] dz,
      input logic [31:0] len);
    lss_pkg::in_item_t seg;
    seg.start_x    = sx;
    seg.start_y    = sy;
    seg.start_z    = sz;
    seg.dir_x      = dx;
    seg.dir_y      = dy;
    seg.dir_z      = dz;
    seg.seg_length = len;
    return seg;
  endfunction

  // Direction components lean toward the extremes now and then.
  function automatic logic [15:0] pick_dir();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return r[15:0];
    endcase
  endfunction

  // Lengths are mostly a whole number of steps plus a remainder, so the step
  // count covers short segments, every count up to the cap, and beyond it.
  function automatic lss_pkg::in_item_t random_segment(input logic [31:0] stp);
    lss_pkg::in_item_t seg;
    logic [63:0]       len;
    logic [63:0]       stp64;
    stp64 = stp;
    seg   = make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                         pick_dir(), 32'h0);
    case ($urandom_range(0, 9))
      0:       len = $urandom;
      1:       len = (stp == 0) ? 64'd0 : 64'($urandom_range(0, stp - 1));
      2:       len = stp64 * $urandom_range(0, 70);
      default: len = stp64 * $urandom_range(0, 70) +
                     ((stp == 0) ? 64'd0 : 64'($urandom_range(0, stp - 1)));
    endcase
    if (len > 64'h0000_0000_ffff_ffff) len = $urandom;
    seg.seg_length = len[lss_pkg::LenW-1:0];
    return seg;
  endfunction

  // Sends one segment beat after a random gap and records its points.
  task automatic send_segment(input lss_pkg::in_item_t seg);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= seg;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_points(seg);
  endtask

  // Holds the sender off until every predicted point has come back.
  task automatic wait_points_done();
    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic set_step(input logic [lss_pkg::LenW-1:0] value);
    wait_points_done();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    step_model = value;
  endtask

  // Default step of 2.0: short, exact, remainder, capped and wrapping segments.
  task automatic test_reset_step_segments();
    send_segment(make_segment(32'h0, 32'h0, 32'h0, 16'h7fff, 16'h0, 16'h0, 32'h0));
    send_segment(make_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              16'h8000, 16'h8000, 16'h8000, 32'h1));
    send_segment(make_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              16'h7fff, 16'h7fff, 16'h7fff, 32'h0001_ffff));
    send_segment(make_segment(32'h0001_0000, 32'hffff_0000, 32'h0, 16'h4000, 16'hc000,
                              16'h5a82, 32'h0002_0000));
    send_segment(make_segment($urandom, $urandom, $urandom, 16'h0, 16'h7fff, 16'h8000,
                              32'h0003_0001));
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'd63 * 32'h0002_0000));
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'd63 * 32'h0002_0000 + 32'h0001_ffff));
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'd64 * 32'h0002_0000));
    send_segment(make_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              16'h7fff, 16'h7fff, 16'h7fff, 32'hffff_ffff));
    send_segment(make_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              16'h8000, 16'h8000, 16'h8000, 32'hffff_ffff));
  endtask

  // Smallest, largest and zero step.
  task automatic test_step_extremes();
    set_step(32'h1);
    send_segment(make_segment($urandom, $urandom, $urandom, 16'h7fff, 16'h8000, 16'h0,
                              32'h0));
    send_segment(make_segment($urandom, $urandom, $urandom, 16'h7fff, 16'h8000, 16'h0,
                              32'h1));
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'd63));
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'd64));
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'hffff_ffff));
    set_step(32'hffff_ffff);
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'h0));
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'hffff_fffe));
    send_segment(make_segment(32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'h7fff, 16'h8000,
                              16'h7fff, 32'hffff_ffff));
    // A zero step caps the count; step points sit at the start with no weight.
    set_step(32'h0);
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'h0));
    send_segment(make_segment($urandom, $urandom, $urandom, pick_dir(), pick_dir(),
                              pick_dir(), 32'hffff_ffff));
    send_segment(random_segment(32'h0));
  endtask

  // Random segments under a series of step sizes, part of the odd phases back to back.
  task automatic test_random_segments();
    logic [lss_pkg::LenW-1:0] steps[5];
    int unsigned              item;
    steps[0] = 32'h0000_4000;
    steps[1] = $urandom_range(1, 32'h0010_0000);
    steps[2] = 32'h0001_0000;
    steps[3] = $urandom;
    steps[4] = 32'h0003_8000;
    foreach (steps[p]) begin
      set_step(steps[p]);
      for (item = 0; item < PhaseItems; item++) begin
        back_to_back = (p % 2 == 1) && (item < 30);
        send_segment(random_segment(step_model));
      end
      back_to_back = 1'b0;
    end
  endtask

  // Every point strobe is matched against the oldest prediction.
  always @(posedge clk) begin : check_points
    lss_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        $error("point with nothing expected: %p", out_data);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (out_data.point_x !== want.point_x) begin
          $error("point_x: expected %0h, got %0h", want.point_x, out_data.point_x);
          error_count++;
        end
        if (out_data.point_y !== want.point_y) begin
          $error("point_y: expected %0h, got %0h", want.point_y, out_data.point_y);
          error_count++;
        end
        if (out_data.point_z !== want.point_z) begin
          $error("point_z: expected %0h, got %0h", want.point_z, out_data.point_z);
          error_count++;
        end
        if (out_data.weight !== want.weight) begin
          $error("weight: expected %0h, got %0h", want.weight, out_data.weight);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          error_count++;
        end
        if (out_data.truncated !== want.truncated) begin
          $error("truncated: expected %0b, got %0b", want.truncated, out_data.truncated);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_line_segment_step_sampler: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    back_to_back = 1'b0;
    step_model   = lss_pkg::STEP_SIZE_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_step_segments();
    test_step_extremes();
    test_random_segments();
    wait_points_done();

    if (error_count == 0) begin
      $display("tb_line_segment_step_sampler: done, clean");
    end else begin
      $display("tb_line_segment_step_sampler: done, errors");
    end
    $finish;
  end

endmodule
